// ===== rtl/biou_pkg.sv =====
// ----------------------------------------------------------------------------
// biou_pkg
// shared widths, constants and the divider stage payload for the box iou core
// ----------------------------------------------------------------------------
package biou_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned ExtW     = CoordW + 1;
  localparam int unsigned OvW      = CoordW;
  localparam int unsigned InterW   = 2 * OvW;
  localparam int unsigned AreaW    = 2 * ExtW;
  localparam int unsigned UniW     = AreaW + 2;
  localparam int unsigned DenW     = AreaW + 1;
  localparam int unsigned QuoW     = 16;
  localparam int unsigned DivStep  = 2;
  localparam int unsigned DivStages = QuoW / DivStep;
  localparam int unsigned Latency  = 3 + DivStages + 1;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DimsW    = 2;

  localparam logic [CfgIdxW-1:0] CfgBoxDims   = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgUnionBias = 1'd1;

  localparam logic [DimsW-1:0]    DimsOneAxis  = 2'd1;
  localparam logic [DimsW-1:0]    DimsReset    = 2'd2;
  localparam logic [CfgDataW-1:0] BiasReset    = 16'd1;
  localparam logic [OvW-1:0]      OneQ4        = 16'd16;

  typedef struct packed {
    logic            valid;
    logic            zero;
    logic            sat;
    logic [DenW-1:0] rem;
    logic [DenW-1:0] den;
    logic [QuoW-1:0] quo;
  } div_t;

endpackage

// ===== rtl/biou_div_stage.sv =====
// ----------------------------------------------------------------------------
// biou_div_stage
// one registered stage of the restoring divider, two quotient bits per stage
// ----------------------------------------------------------------------------
module biou_div_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  biou_pkg::div_t stage_i,
  output biou_pkg::div_t stage_o
);
  import biou_pkg::*;

  div_t stage_d;
  div_t stage_q;

  always_comb begin
    logic [DenW:0]   r;
    logic [DenW-1:0] rem_v;
    logic [QuoW-1:0] quo_v;
    rem_v = stage_i.rem;
    quo_v = stage_i.quo;
    for (int unsigned k = 0; k < DivStep; k++) begin
      r = {rem_v, 1'b0};
      if (r >= {1'b0, stage_i.den}) begin
        r     = r - {1'b0, stage_i.den};
        quo_v = {quo_v[QuoW-2:0], 1'b1};
      end else begin
        quo_v = {quo_v[QuoW-2:0], 1'b0};
      end
      rem_v = r[DenW-1:0];
    end
    stage_d       = stage_i;
    stage_d.rem   = rem_v;
    stage_d.quo   = quo_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

// ===== rtl/box_iou_pair_core.sv =====
// ----------------------------------------------------------------------------
// box_iou_pair_core
// intersection over union of two axis-aligned boxes, fully pipelined
// ----------------------------------------------------------------------------
// Takes one box pair per clock whenever busy_o is low; busy_o is high only in
// the cycle right after reset. Each result appears on overlap_ratio_o with
// result_valid_o for exactly one cycle; there is no backpressure. Each pair
// passes through three arithmetic stages (extents, area multipliers, union
// and denominator) followed by an eight-stage restoring divider that resolves
// two quotient bits per stage, plus the output register. Configuration writes
// are taken in any cycle in which busy_o is low and should only be issued
// while no pair is in flight.
// ----------------------------------------------------------------------------
module box_iou_pair_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [biou_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [biou_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic signed [biou_pkg::CoordW-1:0]  a_min_x_i,
  input  logic signed [biou_pkg::CoordW-1:0]  a_min_y_i,
  input  logic signed [biou_pkg::CoordW-1:0]  a_max_x_i,
  input  logic signed [biou_pkg::CoordW-1:0]  a_max_y_i,
  input  logic signed [biou_pkg::CoordW-1:0]  b_min_x_i,
  input  logic signed [biou_pkg::CoordW-1:0]  b_min_y_i,
  input  logic signed [biou_pkg::CoordW-1:0]  b_max_x_i,
  input  logic signed [biou_pkg::CoordW-1:0]  b_max_y_i,
  output logic                                result_valid_o,
  output logic [biou_pkg::QuoW-1:0]           overlap_ratio_o
);
  import biou_pkg::*;

  // configuration
  logic                busy_q;
  logic [DimsW-1:0]    box_dims_q;
  logic [CfgDataW-1:0] union_bias_q;
  logic                accept;

  assign busy_o      = busy_q;
  assign cfg_ready_o = !busy_q;
  assign accept      = start_i && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b1;
      box_dims_q   <= DimsReset;
      union_bias_q <= BiasReset;
    end else begin
      busy_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgBoxDims:   box_dims_q   <= cfg_data_i[DimsW-1:0];
          CfgUnionBias: union_bias_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // stage 1: overlaps and extents
  logic                   s1_valid_q;
  logic [OvW-1:0]         s1_ov_x_q, s1_ov_y_q, s1_ov_x_d, s1_ov_y_d;
  logic signed [ExtW-1:0] s1_ext_ax_q, s1_ext_ay_q, s1_ext_bx_q, s1_ext_by_q;
  logic signed [ExtW-1:0] s1_ext_ax_d, s1_ext_ay_d, s1_ext_bx_d, s1_ext_by_d;

  function automatic logic [OvW-1:0] overlap(
    input logic signed [CoordW-1:0] amn, input logic signed [CoordW-1:0] amx,
    input logic signed [CoordW-1:0] bmn, input logic signed [CoordW-1:0] bmx
  );
    logic signed [CoordW-1:0] hi;
    logic signed [CoordW-1:0] lo;
    logic signed [ExtW-1:0]   d;
    hi = (amx < bmx) ? amx : bmx;
    lo = (amn > bmn) ? amn : bmn;
    d  = ExtW'(hi) - ExtW'(lo);
    return d[ExtW-1] ? '0 : d[OvW-1:0];
  endfunction

  always_comb begin
    s1_ov_x_d   = overlap(a_min_x_i, a_max_x_i, b_min_x_i, b_max_x_i);
    s1_ext_ax_d = ExtW'(a_max_x_i) - ExtW'(a_min_x_i);
    s1_ext_bx_d = ExtW'(b_max_x_i) - ExtW'(b_min_x_i);
    if (box_dims_q == DimsOneAxis) begin
      s1_ov_y_d   = OneQ4;
      s1_ext_ay_d = ExtW'(OneQ4);
      s1_ext_by_d = ExtW'(OneQ4);
    end else begin
      s1_ov_y_d   = overlap(a_min_y_i, a_max_y_i, b_min_y_i, b_max_y_i);
      s1_ext_ay_d = ExtW'(a_max_y_i) - ExtW'(a_min_y_i);
      s1_ext_by_d = ExtW'(b_max_y_i) - ExtW'(b_min_y_i);
    end
  end

  // stage 2: areas
  logic                    s2_valid_q;
  logic [InterW-1:0]       s2_inter_q;
  logic signed [AreaW-1:0] s2_area_a_q, s2_area_b_q;

  // stage 3: union, denominator, special cases
  div_t            s3_d;
  div_t            s3_q;
  logic signed [UniW-1:0] uni_raw;
  logic [DenW-1:0]        uni;
  logic [DenW-1:0]        den;

  always_comb begin
    uni_raw = UniW'(s2_area_a_q) + UniW'(s2_area_b_q) - UniW'($signed({1'b0, s2_inter_q}));
    uni     = uni_raw[UniW-1] ? '0 : uni_raw[DenW-1:0];
    den     = uni + DenW'(union_bias_q);
    s3_d.valid = s2_valid_q;
    s3_d.zero  = (den == '0);
    s3_d.sat   = (DenW'(s2_inter_q) >= den);
    s3_d.rem   = DenW'(s2_inter_q);
    s3_d.den   = den;
    s3_d.quo   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_q        <= '0;
    end else begin
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q;
      s3_q        <= s3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ov_x_q   <= s1_ov_x_d;
    s1_ov_y_q   <= s1_ov_y_d;
    s1_ext_ax_q <= s1_ext_ax_d;
    s1_ext_ay_q <= s1_ext_ay_d;
    s1_ext_bx_q <= s1_ext_bx_d;
    s1_ext_by_q <= s1_ext_by_d;
    s2_inter_q  <= s1_ov_x_q * s1_ov_y_q;
    s2_area_a_q <= s1_ext_ax_q * s1_ext_ay_q;
    s2_area_b_q <= s1_ext_bx_q * s1_ext_by_q;
  end

  // divider chain
  div_t div_chain [DivStages+1];

  assign div_chain[0] = s3_q;

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    biou_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (div_chain[g]),
      .stage_o (div_chain[g+1])
    );
  end

  // output register
  div_t            div_last;
  logic            out_valid_q;
  logic [QuoW-1:0] out_ratio_q, out_ratio_d;

  assign div_last = div_chain[DivStages];

  always_comb begin
    if (div_last.zero) begin
      out_ratio_d = '0;
    end else if (div_last.sat) begin
      out_ratio_d = '1;
    end else begin
      out_ratio_d = div_last.quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= div_last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ratio_q <= out_ratio_d;
  end

  assign result_valid_o  = out_valid_q;
  assign overlap_ratio_o = out_ratio_q;

  // assertions
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency result_valid_o)
    else $error("accepted transaction gave no result strobe");

  a_result_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, Latency))
    else $error("result strobe does not match accepted transaction");

  a_zero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_last.valid && div_last.zero) |=> (overlap_ratio_o == '0))
    else $error("zero denominator did not give zero ratio");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_last.valid && div_last.sat && !div_last.zero) |=> (overlap_ratio_o == '1))
    else $error("ratio of one or more did not saturate");

  a_s3_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_q.valid && !s3_q.sat) |-> (s3_q.rem < s3_q.den))
    else $error("divider entry remainder not below denominator");

endmodule
